>>> design/ecsm_pkg.sv
// shared types, constants and field helpers for the ec scalar multiplier
package ecsm_pkg;

  localparam int FIELD_W    = 32;
  localparam int SCALAR_W   = 32;
  localparam int CNT_W      = $clog2(FIELD_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef logic [FIELD_W-1:0]  field_t;
  typedef logic [SCALAR_W-1:0] scalar_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'd1;

  typedef enum logic [2:0] {
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_MOD,
    OP_INV,
    OP_SHR
  } op_e;

  typedef enum logic [3:0] {
    R_AX, R_AY, R_BX, R_BY, R_PX, R_PY, R_QX, R_QY,
    R_NUM, R_DEN, R_SLP, R_T, R_CA
  } reg_e;

  typedef struct packed {
    logic go;
    logic load;
    op_e  op;
    reg_e src_a;
    reg_e src_b;
    reg_e dst;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic k_zero;
    logic k_bit;
    logic md_small;
    logic eq_x;
    logic t_zero;
  } dp_status_t;

  function automatic field_t fadd(field_t a, field_t b, field_t md);
    logic [FIELD_W:0] s;
    logic [FIELD_W:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, md};
    return (s >= {1'b0, md}) ? d[FIELD_W-1:0] : s[FIELD_W-1:0];
  endfunction

  function automatic field_t fsub(field_t a, field_t b, field_t md);
    return (a >= b) ? (a - b) : (a - b + md);
  endfunction

endpackage

>>> design/ecsm_datapath.sv
// register file and serial modular arithmetic unit (mul, mod, inverse)
module ecsm_datapath import ecsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  field_t     curve_a_i,
  input  field_t     field_modulus_i,
  input  field_t     point_x_i,
  input  field_t     point_y_i,
  input  scalar_t    scalar_i,
  output dp_status_t status_o,
  output field_t     acc_x_o,
  output field_t     acc_y_o
);

  typedef enum logic [2:0] {
    U_IDLE, U_MUL, U_DIV, U_INV_CHK, U_INV_DIV, U_INV_MUL
  } unit_e;

  unit_e unit_q, unit_d;
  logic  done_q, done_d;

  field_t ax_q, ay_q, bx_q, by_q, px_q, py_q, qx_q, qy_q;
  field_t num_q, den_q, slp_q, t_q, ca_q, md_q;
  scalar_t k_q;

  field_t x_q, x_d, y_q, y_d, macc_q, macc_d;
  field_t dvd_q, dvd_d, dvs_q, dvs_d, rem_q, rem_d, quo_q, quo_d;
  field_t r0_q, r0_d, r1_q, r1_d, s0_q, s0_d, s1_q, s1_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  reg_e  dst_q, dst_d;

  logic   wr_en;
  reg_e   wr_dst;
  field_t wr_data;
  logic   k_shift;

  field_t opa, opb;
  field_t macc_add, x_dbl, rem_nx, quo_nx, rem_sub;
  logic [FIELD_W:0] rem_sh;
  logic   ge;

  function automatic field_t rd(reg_e r, field_t ax, field_t ay, field_t bx,
                                field_t by, field_t px, field_t py, field_t qx,
                                field_t qy, field_t nm, field_t dn, field_t sl,
                                field_t t, field_t ca);
    field_t v;
    v = '0;
    unique case (r)
      R_AX:    v = ax;
      R_AY:    v = ay;
      R_BX:    v = bx;
      R_BY:    v = by;
      R_PX:    v = px;
      R_PY:    v = py;
      R_QX:    v = qx;
      R_QY:    v = qy;
      R_NUM:   v = nm;
      R_DEN:   v = dn;
      R_SLP:   v = sl;
      R_T:     v = t;
      R_CA:    v = ca;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign opa = rd(cmd_i.src_a, ax_q, ay_q, bx_q, by_q, px_q, py_q, qx_q, qy_q,
                  num_q, den_q, slp_q, t_q, ca_q);
  assign opb = rd(cmd_i.src_b, ax_q, ay_q, bx_q, by_q, px_q, py_q, qx_q, qy_q,
                  num_q, den_q, slp_q, t_q, ca_q);

  // one add-and-double step, one restoring-divide step
  assign macc_add = y_q[0] ? fadd(macc_q, x_q, md_q) : macc_q;
  assign x_dbl    = fadd(x_q, x_q, md_q);
  assign rem_sh   = {rem_q, dvd_q[FIELD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs_q};
  assign rem_sub  = rem_sh[FIELD_W-1:0] - dvs_q;
  assign rem_nx   = ge ? rem_sub : rem_sh[FIELD_W-1:0];
  assign quo_nx   = {quo_q[FIELD_W-2:0], ge};

  always_comb begin
    unit_d  = unit_q;
    done_d  = 1'b0;
    x_d = x_q; y_d = y_q; macc_d = macc_q;
    dvd_d = dvd_q; dvs_d = dvs_q; rem_d = rem_q; quo_d = quo_q;
    r0_d = r0_q; r1_d = r1_q; s0_d = s0_q; s1_d = s1_q;
    cnt_d = cnt_q;
    dst_d = dst_q;
    wr_en = 1'b0; wr_dst = dst_q; wr_data = '0;
    k_shift = 1'b0;
    unique case (unit_q)
      U_IDLE: begin
        if (cmd_i.go) begin
          dst_d = cmd_i.dst;
          case (cmd_i.op)
            OP_MOV: begin
              wr_en = 1'b1; wr_dst = cmd_i.dst; wr_data = opa; done_d = 1'b1;
            end
            OP_ADD: begin
              wr_en = 1'b1; wr_dst = cmd_i.dst; done_d = 1'b1;
              wr_data = fadd(opa, opb, md_q);
            end
            OP_SUB: begin
              wr_en = 1'b1; wr_dst = cmd_i.dst; done_d = 1'b1;
              wr_data = fsub(opa, opb, md_q);
            end
            OP_SHR: begin
              k_shift = 1'b1; done_d = 1'b1;
            end
            OP_MUL: begin
              x_d = opa; y_d = opb; macc_d = '0; unit_d = U_MUL;
            end
            OP_MOD: begin
              dvd_d = opa; dvs_d = md_q; rem_d = '0; quo_d = '0; cnt_d = '0;
              unit_d = U_DIV;
            end
            OP_INV: begin
              r0_d = opa; r1_d = md_q; s0_d = field_t'(1); s1_d = '0;
              unit_d = U_INV_CHK;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      U_MUL: begin
        if (y_q == '0) begin
          wr_en = 1'b1; wr_data = macc_q; done_d = 1'b1; unit_d = U_IDLE;
        end else begin
          macc_d = macc_add; x_d = x_dbl; y_d = y_q >> 1;
        end
      end
      U_DIV: begin
        rem_d = rem_nx; quo_d = quo_nx; dvd_d = dvd_q << 1; cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FIELD_W - 1)) begin
          wr_en = 1'b1; wr_data = rem_nx; done_d = 1'b1; unit_d = U_IDLE;
        end
      end
      U_INV_CHK: begin
        if (r1_q == '0) begin
          wr_en = 1'b1; done_d = 1'b1; unit_d = U_IDLE;
          wr_data = (r0_q == field_t'(1)) ? s0_q : '0;
        end else begin
          dvd_d = r0_q; dvs_d = r1_q; rem_d = '0; quo_d = '0; cnt_d = '0;
          unit_d = U_INV_DIV;
        end
      end
      U_INV_DIV: begin
        rem_d = rem_nx; quo_d = quo_nx; dvd_d = dvd_q << 1; cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FIELD_W - 1)) begin
          x_d = quo_nx; y_d = s1_q; macc_d = '0; unit_d = U_INV_MUL;
        end
      end
      U_INV_MUL: begin
        if (y_q == '0) begin
          r0_d = r1_q; r1_d = rem_q; s0_d = s1_q;
          s1_d = fsub(s0_q, macc_q, md_q);
          unit_d = U_INV_CHK;
        end else begin
          macc_d = macc_add; x_d = x_dbl; y_d = y_q >> 1;
        end
      end
      default: unit_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= U_IDLE;
      done_q <= 1'b0;
    end else begin
      unit_q <= unit_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; macc_q <= macc_d;
    dvd_q <= dvd_d; dvs_q <= dvs_d; rem_q <= rem_d; quo_q <= quo_d;
    r0_q <= r0_d; r1_q <= r1_d; s0_q <= s0_d; s1_q <= s1_d;
    cnt_q <= cnt_d;
    dst_q <= dst_d;
    if (k_shift) k_q <= k_q >> 1;
    if (cmd_i.load) begin
      bx_q <= point_x_i;
      by_q <= point_y_i;
      ca_q <= curve_a_i;
      md_q <= field_modulus_i;
      k_q  <= scalar_i;
    end else if (wr_en) begin
      case (wr_dst)
        R_AX:    ax_q  <= wr_data;
        R_AY:    ay_q  <= wr_data;
        R_BX:    bx_q  <= wr_data;
        R_BY:    by_q  <= wr_data;
        R_PX:    px_q  <= wr_data;
        R_PY:    py_q  <= wr_data;
        R_QX:    qx_q  <= wr_data;
        R_QY:    qy_q  <= wr_data;
        R_NUM:   num_q <= wr_data;
        R_DEN:   den_q <= wr_data;
        R_SLP:   slp_q <= wr_data;
        R_T:     t_q   <= wr_data;
        R_CA:    ca_q  <= wr_data;
        default: ;
      endcase
    end
  end

  assign status_o.done     = done_q;
  assign status_o.k_zero   = (k_q == '0);
  assign status_o.k_bit    = k_q[0];
  assign status_o.md_small = (md_q < field_t'(2));
  assign status_o.eq_x     = (px_q == qx_q);
  assign status_o.t_zero   = (t_q == '0);
  assign acc_x_o = ax_q;
  assign acc_y_o = ay_q;

endmodule

>>> design/ecsm_ctrl.sv
// sequencer for double-and-add and the affine point-add steps
module ecsm_ctrl import ecsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       point_at_infinity_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy,
  output logic       result_valid_o,
  output logic       result_inf_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_CHKMD, S_RED_X, S_RED_Y, S_RED_A, S_LOOP, S_CPY, S_CPY2, S_DBL,
    S_LDPX, S_LDPY, S_LDQX, S_LDQY, S_OPP, S_TEST,
    S_D1, S_D2, S_D3, S_D4, S_D5, S_C1, S_C2,
    S_INV, S_SLOPE, S_X1, S_X2, S_X3, S_Y1, S_Y2, S_Y3, S_WX, S_WY,
    S_NEXT, S_SHR, S_OUT
  } state_e;

  state_e state_q, op_next;
  logic   issued_q, dst_acc_q, ainf_q, binf_q, op_state;
  op_e    op;
  reg_e   src_a, src_b, dst;

  // micro-op decode: operation, operands, destination, follow-on state
  always_comb begin
    op_state = 1'b1;
    op = OP_MOV; src_a = R_T; src_b = R_T; dst = R_T;
    op_next = state_q;
    unique case (state_q)
      S_RED_X: begin op = OP_MOD; src_a = R_BX; dst = R_BX; op_next = S_RED_Y; end
      S_RED_Y: begin op = OP_MOD; src_a = R_BY; dst = R_BY; op_next = S_RED_A; end
      S_RED_A: begin op = OP_MOD; src_a = R_CA; dst = R_CA; op_next = S_LOOP; end
      S_CPY:   begin src_a = R_BX; dst = R_AX; op_next = S_CPY2; end
      S_CPY2:  begin src_a = R_BY; dst = R_AY; op_next = S_DBL; end
      S_LDPX:  begin src_a = dst_acc_q ? R_AX : R_BX; dst = R_PX; op_next = S_LDPY; end
      S_LDPY:  begin src_a = dst_acc_q ? R_AY : R_BY; dst = R_PY; op_next = S_LDQX; end
      S_LDQX:  begin src_a = R_BX; dst = R_QX; op_next = S_LDQY; end
      S_LDQY:  begin src_a = R_BY; dst = R_QY; op_next = S_OPP; end
      S_OPP:   begin op = OP_ADD; src_a = R_PY; src_b = R_QY; op_next = S_TEST; end
      S_D1:    begin op = OP_MUL; src_a = R_PX; src_b = R_PX; op_next = S_D2; end
      S_D2: begin
        op = OP_ADD; src_a = R_T; src_b = R_T; dst = R_NUM; op_next = S_D3;
      end
      S_D3: begin
        op = OP_ADD; src_a = R_NUM; src_b = R_T; dst = R_NUM; op_next = S_D4;
      end
      S_D4: begin
        op = OP_ADD; src_a = R_NUM; src_b = R_CA; dst = R_NUM; op_next = S_D5;
      end
      S_D5: begin
        op = OP_ADD; src_a = R_PY; src_b = R_PY; dst = R_DEN; op_next = S_INV;
      end
      S_C1: begin
        op = OP_SUB; src_a = R_QY; src_b = R_PY; dst = R_NUM; op_next = S_C2;
      end
      S_C2: begin
        op = OP_SUB; src_a = R_QX; src_b = R_PX; dst = R_DEN; op_next = S_INV;
      end
      S_INV:   begin op = OP_INV; src_a = R_DEN; dst = R_DEN; op_next = S_SLOPE; end
      S_SLOPE: begin
        op = OP_MUL; src_a = R_NUM; src_b = R_DEN; dst = R_SLP; op_next = S_X1;
      end
      S_X1: begin op = OP_MUL; src_a = R_SLP; src_b = R_SLP; op_next = S_X2; end
      S_X2: begin op = OP_SUB; src_a = R_T; src_b = R_PX; op_next = S_X3; end
      S_X3: begin op = OP_SUB; src_a = R_T; src_b = R_QX; op_next = S_Y1; end
      S_Y1: begin
        op = OP_SUB; src_a = R_PX; src_b = R_T; dst = R_DEN; op_next = S_Y2;
      end
      S_Y2: begin
        op = OP_MUL; src_a = R_SLP; src_b = R_DEN; dst = R_DEN; op_next = S_Y3;
      end
      S_Y3: begin
        op = OP_SUB; src_a = R_DEN; src_b = R_PY; dst = R_DEN; op_next = S_WX;
      end
      S_WX:  begin src_a = R_T; dst = dst_acc_q ? R_AX : R_BX; op_next = S_WY; end
      S_WY:  begin src_a = R_DEN; dst = dst_acc_q ? R_AY : R_BY; op_next = S_NEXT; end
      S_SHR: begin op = OP_SHR; op_next = S_LOOP; end
      default: op_state = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      issued_q  <= 1'b0;
      dst_acc_q <= 1'b0;
      ainf_q    <= 1'b1;
      binf_q    <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            ainf_q  <= 1'b1;
            binf_q  <= point_at_infinity_i;
            state_q <= S_CHKMD;
          end
        end
        S_CHKMD: state_q <= status_i.md_small ? S_OUT : S_RED_X;
        S_LOOP: begin
          if (status_i.k_zero) begin
            state_q <= S_OUT;
          end else if (status_i.k_bit && !binf_q) begin
            if (ainf_q) begin
              state_q <= S_CPY;
            end else begin
              dst_acc_q <= 1'b1;
              state_q   <= S_LDPX;
            end
          end else begin
            state_q <= S_DBL;
          end
        end
        S_DBL: begin
          dst_acc_q <= 1'b0;
          state_q   <= binf_q ? S_SHR : S_LDPX;
        end
        S_TEST: begin
          if (status_i.eq_x && status_i.t_zero) begin
            if (dst_acc_q) ainf_q <= 1'b1;
            else           binf_q <= 1'b1;
            state_q <= S_NEXT;
          end else begin
            state_q <= status_i.eq_x ? S_D1 : S_C1;
          end
        end
        S_NEXT: state_q <= dst_acc_q ? S_DBL : S_SHR;
        S_OUT:  state_q <= S_IDLE;
        default: begin
          if (!issued_q) begin
            issued_q <= 1'b1;
          end else if (status_i.done) begin
            issued_q <= 1'b0;
            if (state_q == S_CPY2) ainf_q <= 1'b0;
            state_q <= op_next;
          end
        end
      endcase
    end
  end

  assign cmd_o.go    = op_state && !issued_q;
  assign cmd_o.load  = start && (state_q == S_IDLE);
  assign cmd_o.op    = op;
  assign cmd_o.src_a = src_a;
  assign cmd_o.src_b = src_b;
  assign cmd_o.dst   = dst;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_OUT);
  assign result_inf_o   = ainf_q;

endmodule

>>> design/ec_point_scalar_multiply_top.sv
// top level of the elliptic curve scalar multiplier
//
// computes k*P on y^2 = x^3 + a*x + b over the field set by field_modulus,
// in affine coordinates, by right-to-left double-and-add starting from the
// point at infinity. a word is taken when start is high while busy is low;
// point_x, point_y and curve_a are reduced modulo the modulus first. the
// result shows on result_x_o / result_y_o / result_at_infinity_o for exactly
// one cycle with result_valid_o high, and the receiver cannot hold it off;
// busy drops the cycle after. coordinates are zero when the result is at
// infinity, and a modulus below two gives infinity at once.
// every op is issued by the controller and runs on one shared serial unit.
// a modular multiply takes one add-and-double step per bit of its second
// operand, a reduction is a bitwise restoring divide, and each inverse
// runs extended euclid, each quotient step being one divide plus one
// serial multiply. a point add or double is dominated by the inverse.
// configuration (curve_a at index 0, field_modulus at index 1) is written
// with cfg_we_i and must only change while busy is low
module ec_point_scalar_multiply_top import ecsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // command side
  input  logic                  start,
  output logic                  busy,
  input  logic [31:0]           point_x_i,
  input  logic [31:0]           point_y_i,
  input  logic                  point_at_infinity_i,
  input  logic [31:0]           scalar_i,
  // result side
  output logic                  result_valid_o,
  output logic [31:0]           result_x_o,
  output logic [31:0]           result_y_o,
  output logic                  result_at_infinity_o
);

  field_t     curve_a_q, field_modulus_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  field_t     acc_x, acc_y;
  logic       res_inf;

  // config registers, reset to the small default curve
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_a_q       <= field_t'(1);
      field_modulus_q <= field_t'(11);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CURVE_A: curve_a_q       <= cfg_wdata_i;
        CFG_MODULUS: field_modulus_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ecsm_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .point_at_infinity_i (point_at_infinity_i),
    .status_i            (status),
    .cmd_o               (cmd),
    .busy                (busy),
    .result_valid_o      (result_valid_o),
    .result_inf_o        (res_inf)
  );

  ecsm_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .curve_a_i       (curve_a_q),
    .field_modulus_i (field_modulus_q),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .scalar_i        (scalar_i),
    .status_o        (status),
    .acc_x_o         (acc_x),
    .acc_y_o         (acc_y)
  );

  // infinity reads out as zero coordinates
  assign result_x_o           = res_inf ? '0 : acc_x;
  assign result_y_o           = res_inf ? '0 : acc_y;
  assign result_at_infinity_o = res_inf;

endmodule

>>> design/ecsm_checker.sv
// port-level checks for the scalar multiplier, bound to the top level
module ecsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [31:0] result_x_o,
  input logic [31:0] result_y_o,
  input logic        result_at_infinity_o
);

  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result word held longer than one cycle");

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result word outside a busy period");

  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_at_infinity_o) |-> (result_x_o == 32'd0 && result_y_o == 32'd0))
    else $error("infinity result with nonzero coordinates");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(result_valid_o))
    else $error("busy dropped without a result word");

endmodule

bind ec_point_scalar_multiply_top ecsm_checker u_ecsm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .start                (start),
  .busy                 (busy),
  .result_valid_o       (result_valid_o),
  .result_x_o           (result_x_o),
  .result_y_o           (result_y_o),
  .result_at_infinity_o (result_at_infinity_o)
);
